[design/sfcd_pkg.sv]
package sfcd_pkg;

  localparam int FRAME_BYTES  = 25;
  localparam int NUM_CHANNELS = 16;
  localparam int CH_BITS      = 11;
  localparam int DATA_BYTES   = 22;
  localparam int DATA_BITS    = DATA_BYTES * 8;

  typedef logic [7:0]          byte_t;
  typedef logic [CH_BITS-1:0]  chan_raw_t;
  typedef logic signed [11:0]  chan_val_t;
  typedef logic [3:0]          chan_idx_t;
  typedef logic [DATA_BITS-1:0] frame_data_t;

  localparam byte_t HEADER_BYTE = 8'h0F;
  localparam byte_t FOOTER_BYTE = 8'h00;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LOW_LIMIT    = 3'd0;
  localparam cfg_idx_t REG_HIGH_LIMIT   = 3'd1;
  localparam cfg_idx_t REG_CENTER_VALUE = 3'd2;
  localparam cfg_idx_t REG_DEAD_ZONE    = 3'd3;

  localparam chan_raw_t LOW_LIMIT_RST    = 11'd172;
  localparam chan_raw_t HIGH_LIMIT_RST   = 11'd1811;
  localparam chan_raw_t CENTER_VALUE_RST = 11'd992;
  localparam chan_raw_t DEAD_ZONE_RST    = 11'd10;

  localparam chan_idx_t LAST_CHANNEL = 4'd15;

  typedef struct packed {
    chan_raw_t low_limit;
    chan_raw_t high_limit;
    chan_raw_t center_value;
    chan_raw_t dead_zone;
  } cond_cfg_t;

endpackage

[design/sfcd_if.sv]
interface sfcd_byte_if import sfcd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcd_chan_if import sfcd_pkg::*; ();
  logic      valid;
  logic      ready;
  chan_idx_t channel_index;
  chan_val_t channel_value;
  logic      link_alive;
  logic      last;

  modport source (output valid, output channel_index, output channel_value,
                  output link_alive, output last, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input link_alive, input last, output ready);
endinterface

[design/sbus_frame_channel_decoder.sv]
// A footer byte that completes a frame loads the snapshot register, which moves into the
// serializer and then to the output register as channel 0; the rest follow one beat per cycle
// while out_bus.ready holds, 16 beats per frame. Input takes one byte per cycle unless stalled;
// a second frame found while the serializer is busy is held in one snapshot register that stalls input.
// Reset (rst, synchronous): the 25-byte window clears to zero, the limits return to
// their defaults and all pending frames and beats are dropped.
module sbus_frame_channel_decoder import sfcd_pkg::*; #(
  parameter int CONDITIONED_CHANNELS = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  cfg_idx_t        cfg_index,
  input  chan_raw_t       cfg_data,
  sfcd_byte_if.sink       in_bus,
  sfcd_chan_if.source     out_bus
);

  cond_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit    <= LOW_LIMIT_RST;
      cfg.high_limit   <= HIGH_LIMIT_RST;
      cfg.center_value <= CENTER_VALUE_RST;
      cfg.dead_zone    <= DEAD_ZONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_LIMIT:    cfg.low_limit    <= cfg_data;
        REG_HIGH_LIMIT:   cfg.high_limit   <= cfg_data;
        REG_CENTER_VALUE: cfg.center_value <= cfg_data;
        REG_DEAD_ZONE:    cfg.dead_zone    <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte window: cell 0 oldest, cell FRAME_BYTES-1 newest
  byte_t win [FRAME_BYTES];
  logic  in_fire;
  logic  snap_valid;
  logic  ser_active;

  // an idle serializer takes the snapshot this cycle, so a new one may land
  assign in_bus.ready = !snap_valid || !ser_active;
  assign in_fire      = in_bus.valid && in_bus.ready;

  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
    if (i == FRAME_BYTES - 1) begin : g_tail
      sfcd_byte_cell u_cell (
        .clk(clk), .rst(rst), .shift(in_fire), .d_in(in_bus.rx_byte), .q(win[i])
      );
    end else begin : g_body
      sfcd_byte_cell u_cell (
        .clk(clk), .rst(rst), .shift(in_fire), .d_in(win[i+1]), .q(win[i])
      );
    end
  end

  // match on the window as it stands after this beat shifts in
  logic        match;
  frame_data_t snap_data_next;

  assign match = (win[1] == HEADER_BYTE) && (in_bus.rx_byte == FOOTER_BYTE);

  always_comb begin
    for (int b = 0; b < DATA_BYTES; b++) begin
      snap_data_next[8*b +: 8] = win[b+2];
    end
  end

  frame_data_t snap_data;
  logic        snap_alive;

  // serializer
  frame_data_t ser_data;
  logic        ser_alive;
  chan_idx_t   ser_count;
  logic        out_valid;
  logic        adv;
  logic        load;

  assign adv  = ser_active && (!out_valid || out_bus.ready);
  assign load = snap_valid && (!ser_active || (adv && ser_count == LAST_CHANNEL));

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_fire && match) begin
      snap_valid <= 1'b1;
    end else if (load) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && match) begin
      snap_data  <= snap_data_next;
      snap_alive <= (win[FRAME_BYTES-1] == 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_active <= 1'b0;
      ser_count  <= '0;
    end else if (load) begin
      ser_active <= 1'b1;
      ser_count  <= '0;
    end else if (adv) begin
      ser_active <= (ser_count != LAST_CHANNEL);
      ser_count  <= ser_count + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_data  <= snap_data;
      ser_alive <= snap_alive;
    end else if (adv) begin
      ser_data  <= ser_data >> CH_BITS;
    end
  end

  chan_val_t cond_value;
  logic      cond_en;

  assign cond_en = {1'b0, ser_count} < 5'(CONDITIONED_CHANNELS);

  sfcd_condition u_cond (
    .cfg   (cfg),
    .enable(cond_en),
    .raw   (ser_data[CH_BITS-1:0]),
    .value (cond_value)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bus.channel_index <= ser_count;
      out_bus.channel_value <= cond_value;
      out_bus.link_alive    <= ser_alive;
      out_bus.last          <= (ser_count == LAST_CHANNEL);
    end
  end

  assign out_bus.valid = out_valid;

endmodule

[design/sfcd_byte_cell.sv]
module sfcd_byte_cell import sfcd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  byte_t d_in,
  output byte_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d_in;
    end
  end

endmodule

[design/sfcd_condition.sv]
module sfcd_condition import sfcd_pkg::*; (
  input  cond_cfg_t cfg,
  input  logic      enable,
  input  chan_raw_t raw,
  output chan_val_t value
);

  chan_raw_t         clamped;
  logic signed [11:0] diff;
  chan_raw_t         mag;

  always_comb begin
    // out-of-range samples snap to center
    if (raw < cfg.low_limit || raw > cfg.high_limit) begin
      clamped = cfg.center_value;
    end else begin
      clamped = raw;
    end
    diff = $signed({1'b0, clamped}) - $signed({1'b0, cfg.center_value});
    mag  = diff[11] ? chan_raw_t'(-diff) : diff[10:0];
    if (!enable) begin
      value = $signed({1'b0, raw});
    end else if (mag <= cfg.dead_zone) begin
      value = '0;
    end else begin
      value = diff;
    end
  end

endmodule

[design/sfcd_checker.sv]
module sfcd_checker import sfcd_pkg::*; #(
  parameter int CONDITIONED_CHANNELS = 4
) (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input chan_idx_t channel_index,
  input chan_val_t channel_value,
  input logic      link_alive,
  input logic      last
);

  // a stalled beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel_index)
      && $stable(channel_value) && $stable(link_alive) && $stable(last))
    else $error("output beat changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (channel_index == LAST_CHANNEL)))
    else $error("last flag does not match channel 15");

  a_raw: assert property (@(posedge clk) disable iff (rst)
    out_valid && ({1'b0, channel_index} >= 5'(CONDITIONED_CHANNELS))
      |-> !channel_value[11])
    else $error("raw channel carries a negative value");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sbus_frame_channel_decoder sfcd_checker #(
  .CONDITIONED_CHANNELS(CONDITIONED_CHANNELS)
) u_sfcd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .channel_index(out_bus.channel_index),
  .channel_value(out_bus.channel_value),
  .link_alive   (out_bus.link_alive),
  .last         (out_bus.last)
);

[dv/sbus_frame_channel_decoder_tb.sv]
module sbus_frame_channel_decoder_tb;
  import sfcd_pkg::*;

  localparam int COND_CHANNELS = 4;
  localparam int N_PHASES      = 4;
  localparam int PHASE_BYTES   = 24;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    chan_idx_t idx;
    chan_val_t val;
    logic      alive;
    logic      last;
  } beat_t;

  // frame outcome typed in by hand; overrides the decode when on is set
  typedef struct packed {
    logic      on;
    chan_val_t cond;
    chan_raw_t raw;
    logic      alive;
  } known_t;

  localparam known_t NO_KNOWN = '0;

  typedef struct {
    logic [COND_CHANNELS-1:0][CH_BITS-1:0] cond;
    chan_raw_t fill;
    byte_t     flags;
    int        tail;
    logic      typed;
    chan_val_t exp_cond;
    chan_raw_t exp_raw;
    logic      exp_alive;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  chan_raw_t cfg_data;

  sfcd_byte_if in_if ();
  sfcd_chan_if out_if ();

  sbus_frame_channel_decoder #(
    .CONDITIONED_CHANNELS(COND_CHANNELS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_bus   (in_if),
    .out_bus  (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_t     win [FRAME_BYTES];
  chan_raw_t lim_lo, lim_hi, ctr_val, dz_val;
  beat_t     pending_beats [$];
  int        gap_pct = 0;
  int        stall_pct = 0;
  int        mismatches = 0;

  // shift one byte into the window and queue the sixteen channel beats of a match
  function automatic void decode_byte(byte_t b, known_t kn);
    frame_data_t d;
    chan_raw_t   raw;
    int          v;
    beat_t       bt;
    for (int i = 0; i < FRAME_BYTES - 1; i++) win[i] = win[i + 1];
    win[FRAME_BYTES - 1] = b;
    if (win[0] != HEADER_BYTE || win[FRAME_BYTES - 1] != FOOTER_BYTE) return;
    for (int i = 0; i < DATA_BYTES; i++) d[8*i +: 8] = win[i + 1];
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      raw = d[CH_BITS*k +: CH_BITS];
      if (k >= COND_CHANNELS) begin
        v = int'(raw);
      end else begin
        if (raw < lim_lo || raw > lim_hi) raw = ctr_val;
        v = int'(raw) - int'(ctr_val);
        if ((v < 0 ? -v : v) <= int'(dz_val)) v = 0;
      end
      if (kn.on) v = (k < COND_CHANNELS) ? int'(kn.cond) : int'(kn.raw);
      bt.idx   = chan_idx_t'(k);
      bt.val   = chan_val_t'(v);
      bt.alive = kn.on ? kn.alive : (win[FRAME_BYTES - 2] == '0);
      bt.last  = (bt.idx == LAST_CHANNEL);
      pending_beats.push_back(bt);
    end
  endfunction

  function automatic frame_data_t rand_frame();
    frame_data_t d;
    chan_raw_t   ofs;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      ofs = chan_raw_t'($urandom_range(2));
      // bias toward the limits and the dead zone edges
      case ($urandom_range(5))
        0:       d[CH_BITS*k +: CH_BITS] = lim_lo + ofs - 11'd1;
        1:       d[CH_BITS*k +: CH_BITS] = lim_hi + ofs - 11'd1;
        2:       d[CH_BITS*k +: CH_BITS] = ctr_val + dz_val + ofs - 11'd1;
        3:       d[CH_BITS*k +: CH_BITS] = ctr_val - dz_val + ofs - 11'd1;
        4:       d[CH_BITS*k +: CH_BITS] = $urandom_range(1) ? '1 : '0;
        default: d[CH_BITS*k +: CH_BITS] = chan_raw_t'($urandom_range(2047));
      endcase
    end
    return d;
  endfunction

  function automatic byte_t rand_flags();
    return $urandom_range(1) ? 8'h00 : byte_t'($urandom_range(255));
  endfunction

  task automatic send_byte(byte_t b, known_t kn);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    decode_byte(b, kn);
  endtask

  task automatic send_frame(frame_data_t d, byte_t flags, byte_t footer, int tail, known_t kn);
    send_byte(HEADER_BYTE, NO_KNOWN);
    for (int i = 0; i < DATA_BYTES; i++) send_byte(d[8*i +: 8], NO_KNOWN);
    send_byte(flags, NO_KNOWN);
    send_byte(footer, kn);
    repeat (tail) send_byte(FOOTER_BYTE, NO_KNOWN);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(cfg_idx_t idx, chan_raw_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_LOW_LIMIT:    lim_lo = val;
      REG_HIGH_LIMIT:   lim_hi = val;
      REG_CENTER_VALUE: ctr_val = val;
      REG_DEAD_ZONE:    dz_val = val;
      default: ;
    endcase
  endtask

  initial begin : chan_sink
    beat_t want;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (pending_beats.size() == 0) begin
          $error("channel beat with no frame pending: channel_index %0d",
                 out_if.channel_index);
          mismatches++;
        end else begin
          want = pending_beats.pop_front();
          if (out_if.channel_index !== want.idx) begin
            $error("channel_index: expected %0d, actual %0d", want.idx, out_if.channel_index);
            mismatches++;
          end
          if (out_if.channel_value !== want.val) begin
            $error("channel_value: expected %0d, actual %0d", $signed(want.val),
                   $signed(out_if.channel_value));
            mismatches++;
          end
          if (out_if.link_alive !== want.alive) begin
            $error("link_alive: expected %0d, actual %0d", want.alive, out_if.link_alive);
            mismatches++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_if.last);
            mismatches++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    dir_row_t    rows [5];
    known_t      kn;
    frame_data_t d;
    int          sent, n, pick, waited;
    chan_raw_t   v_lo, v_hi, v_ctr, v_dz;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_LOW_LIMIT;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    foreach (win[i]) win[i] = '0;
    lim_lo  = LOW_LIMIT_RST;
    lim_hi  = HIGH_LIMIT_RST;
    ctr_val = CENTER_VALUE_RST;
    dz_val  = DEAD_ZONE_RST;
    // conditioned channels listed highest first
    rows = '{
      '{{4{11'd0}}, 11'd0, 8'h00, 0, 1'b1, 12'sd0, 11'd0, 1'b1},
      '{{4{11'd2047}}, 11'd2047, 8'hFF, 0, 1'b1, 12'sd0, 11'd2047, 1'b0},
      // both limits and one step past each
      '{{11'd1812, 11'd171, 11'd1811, 11'd172}, 11'd1234, 8'h00, 0, 1'b0, 12'sd0, 11'd0, 1'b0},
      // dead zone edges around the center
      '{{11'd1003, 11'd981, 11'd1002, 11'd982}, 11'h555, 8'h01, 0, 1'b0, 12'sd0, 11'd0, 1'b0},
      // first data byte doubles as a header: one more footer closes an overlapping frame
      '{{11'd992, 11'd992, 11'd992, 11'h00F}, 11'h2AA, 8'h00, 1, 1'b0, 12'sd0, 11'd0, 1'b0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      d = '0;
      for (int k = 0; k < NUM_CHANNELS; k++)
        d[CH_BITS*k +: CH_BITS] = (k < COND_CHANNELS) ? rows[r].cond[k] : rows[r].fill;
      kn = '{rows[r].typed, rows[r].exp_cond, rows[r].exp_raw, rows[r].exp_alive};
      send_frame(d, rows[r].flags, FOOTER_BYTE, rows[r].tail, kn);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // drain before touching the limits
      in_if.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 85; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 85; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      case (ph)
        0: begin v_lo = 11'd172;  v_hi = 11'd1811; v_ctr = 11'd992;  v_dz = 11'd10;   end
        1: begin v_lo = 11'd0;    v_hi = 11'd2047; v_ctr = 11'd0;    v_dz = 11'd0;    end
        2: begin v_lo = 11'd0;    v_hi = 11'd2047; v_ctr = 11'd2047; v_dz = 11'd0;    end
        // crossed limits: every conditioned channel reads zero
        default: begin v_lo = 11'd2047; v_hi = 11'd0; v_ctr = 11'd1024; v_dz = 11'd5; end
      endcase
      write_reg(REG_LOW_LIMIT, v_lo);
      write_reg(REG_HIGH_LIMIT, v_hi);
      write_reg(REG_CENTER_VALUE, v_ctr);
      write_reg(REG_DEAD_ZONE, v_dz);
      // unmapped index: must leave every limit alone
      write_reg(cfg_idx_t'($urandom_range(int'(REG_DEAD_ZONE) + 1, (1 << CFG_IDX_W) - 1)),
                chan_raw_t'($urandom_range(2047)));
      cfg_we <= 1'b0;

      sent = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(9);
        d = rand_frame();
        if (pick <= 5) begin
          send_frame(d, rand_flags(), FOOTER_BYTE, 0, NO_KNOWN);
          sent += FRAME_BYTES;
        end else if (pick == 6) begin
          d[7:0] = HEADER_BYTE;
          send_frame(d, rand_flags(), FOOTER_BYTE, 1, NO_KNOWN);
          sent += FRAME_BYTES + 1;
        end else if (pick == 7) begin
          if ($urandom_range(1)) begin
            send_frame(d, rand_flags(), byte_t'($urandom_range(1, 255)), 0, NO_KNOWN);
            sent += FRAME_BYTES;
          end else begin
            // truncated frame
            n = $urandom_range(1, DATA_BYTES);
            send_byte(HEADER_BYTE, NO_KNOWN);
            for (int i = 0; i < n; i++) send_byte(d[8*i +: 8], NO_KNOWN);
            sent += n + 1;
          end
        end else begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(2))
              0:       send_byte(HEADER_BYTE, NO_KNOWN);
              1:       send_byte(FOOTER_BYTE, NO_KNOWN);
              default: send_byte(byte_t'($urandom_range(255)), NO_KNOWN);
            endcase
          end
          sent += n;
        end
      end
    end

    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_beats.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
